/* rtl/udec_pkg.sv */
// Shared types and constants of the UTF-8 validating decoder.
package udec_pkg;

  localparam int unsigned CpW   = 21;
  localparam int unsigned LenW  = 3;
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW = $clog2(QDepth);
  localparam int unsigned QLvlW = $clog2(QDepth + 1);

  localparam logic [7:0] LeadTwoLo   = 8'hC2;
  localparam logic [7:0] LeadTwoHi   = 8'hDF;
  localparam logic [7:0] LeadThreeLo = 8'hE0;
  localparam logic [7:0] LeadThreeHi = 8'hEF;
  localparam logic [7:0] LeadFourLo  = 8'hF0;
  localparam logic [7:0] LeadFourHi  = 8'hF4;
  localparam logic [7:0] LeadBadLo   = 8'hF5;
  localparam logic [7:0] LeadBadHi   = 8'hF7;
  localparam logic [7:0] LeadOverC0  = 8'hC0;
  localparam logic [7:0] LeadOverC1  = 8'hC1;
  localparam logic [7:0] LeadSurr    = 8'hED;
  localparam logic [7:0] ContMask    = 8'h3F;
  localparam logic [7:0] SecE0Min    = 8'hA0;
  localparam logic [7:0] SecEdMax    = 8'h9F;
  localparam logic [7:0] SecF0Min    = 8'h90;
  localparam logic [7:0] SecF4Max    = 8'h8F;

  typedef struct packed {
    logic [CpW-1:0]  code_point;
    logic [LenW-1:0] seq_length;
    logic            is_valid;
    logic            run_last;
  } res_t;

  typedef struct packed {
    logic [QLvlW-1:0] level;
    logic             ready;
  } q_stat_t;

endpackage

/* rtl/udec_front.sv */
// Front part: accepts bytes, tracks the pending sequence and forms up to two results per byte.
module udec_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  logic [7:0]    data_byte_i,
  input  logic          end_of_source_i,
  output logic [1:0]    push_n_o,
  output udec_pkg::res_t res0_o,
  output udec_pkg::res_t res1_o
);
  import udec_pkg::*;

  logic [2:0]     exp_q, exp_d, got_q, got_d;
  logic [CpW-1:0] acc_q, acc_d;
  logic [7:0]     lead_q, lead_d, sec_q, sec_d;

  res_t c0, c1, c2;
  logic c0_v, c1_v, c2_v;

  function automatic logic bad_lead(input logic [7:0] b);
    return b == LeadOverC0 || b == LeadOverC1 || (b >= LeadBadLo && b <= LeadBadHi);
  endfunction

  function automatic res_t mk_err(input logic [2:0] len);
    res_t r;
    r.code_point = '0;
    r.seq_length = len;
    r.is_valid   = 1'b0;
    r.run_last   = 1'b0;
    return r;
  endfunction

  always_comb begin
    logic is_cont;
    logic do_start;
    logic bad;
    is_cont  = data_byte_i[7:6] == 2'b10;
    do_start = 1'b0;
    bad      = 1'b0;
    exp_d = exp_q;
    got_d = got_q;
    acc_d = acc_q;
    lead_d = lead_q;
    sec_d = sec_q;
    c0_v = 1'b0;
    c1_v = 1'b0;
    c2_v = 1'b0;
    c0 = mk_err(got_q);
    c1 = mk_err(3'd1);
    c2 = mk_err(3'd1);

    if (exp_q == 3'd0) begin
      do_start = 1'b1;
    end else if (is_cont) begin
      if (got_q == 3'd1) begin
        sec_d = data_byte_i;
      end
      got_d = got_q + 3'd1;
      if (!bad_lead(lead_q)) begin
        acc_d = {acc_q[CpW-7:0], data_byte_i[5:0] & ContMask[5:0]};
      end
      if (got_d >= exp_q) begin
        bad = bad_lead(lead_q) ||
              (lead_q == LeadThreeLo && sec_d < SecE0Min) ||
              (lead_q == LeadSurr && sec_d > SecEdMax) ||
              (lead_q == LeadFourLo && sec_d < SecF0Min) ||
              (lead_q == LeadFourHi && sec_d > SecF4Max);
        c1_v = 1'b1;
        c1 = mk_err(exp_q);
        if (!bad) begin
          c1.code_point = acc_d;
          c1.is_valid   = 1'b1;
        end
        exp_d = '0;
        got_d = '0;
        acc_d = '0;
        lead_d = '0;
        sec_d = '0;
      end
    end else begin
      c0_v = 1'b1;
      exp_d = '0;
      got_d = '0;
      acc_d = '0;
      lead_d = '0;
      sec_d = '0;
      do_start = 1'b1;
    end

    if (do_start) begin
      if (data_byte_i[7] == 1'b0) begin
        c1_v = 1'b1;
        c1.code_point = CpW'(data_byte_i);
        c1.is_valid = 1'b1;
      end else if ((data_byte_i >= LeadTwoLo && data_byte_i <= LeadTwoHi) ||
                   (data_byte_i >= LeadThreeLo && data_byte_i <= LeadFourHi) ||
                   bad_lead(data_byte_i)) begin
        got_d  = 3'd1;
        lead_d = data_byte_i;
        sec_d  = '0;
        if (bad_lead(data_byte_i)) begin
          acc_d = '0;
          exp_d = (data_byte_i[5] == 1'b0) ? 3'd2 : 3'd4;
        end else if (data_byte_i <= LeadTwoHi) begin
          acc_d = CpW'(data_byte_i[4:0]);
          exp_d = 3'd2;
        end else if (data_byte_i <= LeadThreeHi) begin
          acc_d = CpW'(data_byte_i[3:0]);
          exp_d = 3'd3;
        end else begin
          acc_d = CpW'(data_byte_i[2:0]);
          exp_d = 3'd4;
        end
      end else begin
        c1_v = 1'b1;
      end
    end

    if (end_of_source_i && exp_d != 3'd0) begin
      c2_v = 1'b1;
      c2 = mk_err(got_d);
      exp_d = '0;
      got_d = '0;
      acc_d = '0;
      lead_d = '0;
      sec_d = '0;
    end

    res0_o = c0_v ? c0 : (c1_v ? c1 : c2);
    res1_o = (c0_v && c1_v) ? c1 : c2;
    push_n_o = accept_i ? (2'(c0_v) + 2'(c1_v) + 2'(c2_v)) : 2'd0;
    res0_o.run_last = (push_n_o == 2'd1);
    res1_o.run_last = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q  <= '0;
      got_q  <= '0;
      acc_q  <= '0;
      lead_q <= '0;
      sec_q  <= '0;
    end else if (accept_i) begin
      exp_q  <= exp_d;
      got_q  <= got_d;
      acc_q  <= acc_d;
      lead_q <= lead_d;
      sec_q  <= sec_d;
    end
  end

endmodule

/* rtl/udec_queue.sv */
// Result queue between the front and back parts, taking up to two entries per cycle.
module udec_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [1:0]        push_n_i,
  input  udec_pkg::res_t    res0_i,
  input  udec_pkg::res_t    res1_i,
  input  logic              pop_i,
  output logic              head_valid_o,
  output udec_pkg::res_t    head_o,
  output udec_pkg::q_stat_t stat_o
);
  import udec_pkg::*;

  res_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QLvlW-1:0] level_q, level_d;
  logic [QPtrW-1:0] wr_ptr1;

  assign wr_ptr1 = wr_ptr_q + QPtrW'(1);
  assign level_d = level_q + QLvlW'(push_n_i) - QLvlW'(pop_i);

  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) begin
      mem_q[wr_ptr_q] <= res0_i;
    end
    if (push_n_i == 2'd2) begin
      mem_q[wr_ptr1] <= res1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + QPtrW'(push_n_i);
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
      level_q <= level_d;
    end
  end

  assign head_valid_o = level_q != '0;
  assign head_o       = mem_q[rd_ptr_q];
  assign stat_o.level = level_q;
  assign stat_o.ready = level_q <= QLvlW'(QDepth - 2);

endmodule

/* rtl/udec_back.sv */
// Back part: moves queued results into the output register and holds them under stall.
module udec_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           head_valid_i,
  input  udec_pkg::res_t head_i,
  output logic           pop_o,
  input  logic           out_ready_i,
  output logic           out_valid_o,
  output udec_pkg::res_t out_res_o
);
  import udec_pkg::*;

  logic out_valid_q;
  res_t out_res_q;

  assign pop_o = head_valid_i && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_ready_i) begin
      out_valid_q <= head_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_res_q <= head_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

endmodule

/* rtl/utf8_validating_decoder_top.sv */
// Top level of the strict UTF-8 validating decoder.
//
// Channel  Dir  tdata (low bit up)                           tlast          tuser
// s_axis   in   data_byte[7:0]                               end_of_source  -
// m_axis   out  code_point[20:0] seq_length[23:21]
//               is_valid[24] zero[31:25]                     run_last       -
//
// A byte is taken every cycle while the result queue has two free entries; one
// result leaves per cycle while m_axis_tready is high, so bytes that yield two
// results build up in the queue. Results pass the queue, then the output register.
// Reset clears the sequence state, the queue pointers and level, and output valid.
// An output stall fills the four-entry queue to three or four, then holds off input.
module utf8_validating_decoder_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // data_byte[7:0]
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // code_point[20:0], seq_length[23:21], is_valid[24]
  output logic        m_axis_tlast_o
);
  import udec_pkg::*;

  logic       accept;
  logic [1:0] push_n;
  res_t       res0, res1, head, out_res;
  logic       head_valid, pop;
  q_stat_t    q_stat;

  assign s_axis_tready_o = q_stat.ready;
  assign accept = s_axis_tvalid_i && q_stat.ready;

  udec_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .data_byte_i     (s_axis_tdata_i),
    .end_of_source_i (s_axis_tlast_i),
    .push_n_o        (push_n),
    .res0_o          (res0),
    .res1_o          (res1)
  );

  udec_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_n_i     (push_n),
    .res0_i       (res0),
    .res1_i       (res1),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head),
    .stat_o       (q_stat)
  );

  udec_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_ready_i  (m_axis_tready_i),
    .out_valid_o  (m_axis_tvalid_o),
    .out_res_o    (out_res)
  );

  assign m_axis_tdata_o = {7'b0, out_res.is_valid, out_res.seq_length, out_res.code_point};
  assign m_axis_tlast_o = out_res.run_last;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_n != 2'd0) |-> s_axis_tready_o)
    else $error("Results were written to a queue without room.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_stat.level <= QLvlW'(QDepth))
    else $error("Result queue level exceeds its depth.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !out_res.is_valid) |-> (out_res.code_point == '0))
    else $error("Invalid result carries a nonzero code point.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (out_res.seq_length != 3'd0 && out_res.seq_length <= 3'd4))
    else $error("Result length out of range.");

endmodule
